@@ rtl/vlbp_pkg.sv @@
`default_nettype none

package vlbp_pkg;

	localparam int BLOCK_W      = 64;
	localparam int WORD_W       = 32;
	localparam int VALUE_W      = 63;
	localparam int LEN_W        = 6;
	localparam int PAYLOAD_BITS = 63;

	// command codes carried on the cmd field
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_END    = 1'b1;

	// packing result handed from the datapath to the top level
	typedef struct packed {
		logic               update;      // block state changes
		logic               emit;        // a finished block leaves
		logic [BLOCK_W-1:0] emit_block;
		logic [BLOCK_W-1:0] next_block;
		logic [LEN_W-1:0]   next_fill;
	} pack_res_t;

endpackage

`default_nettype wire

@@ rtl/vlbp_ifs.sv @@
`default_nettype none

interface vlbp_in_if import vlbp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [VALUE_W-1:0] field_value;
	logic [LEN_W-1:0]   field_length;

	modport source (output valid, cmd, field_value, field_length, input ready);
	modport sink   (input valid, cmd, field_value, field_length, output ready);
endinterface

interface vlbp_out_if import vlbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_word;
	logic              last_of_run;

	modport source (output valid, out_word, last_of_run, input ready);
	modport sink   (input valid, out_word, last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/vlbp_pack.sv @@
`default_nettype none

// Single-pass packing datapath: merges one field into the current block, or closes the block on an end command.
module vlbp_pack import vlbp_pkg::*; #(
	parameter int PAYLOAD_BITS = vlbp_pkg::PAYLOAD_BITS
) (
	input  wire logic               cmd,
	input  wire logic [VALUE_W-1:0] field_value,
	input  wire logic [LEN_W-1:0]   field_length,
	input  wire logic [BLOCK_W-1:0] block_q,
	input  wire logic [LEN_W-1:0]   fill_q,
	output pack_res_t               res
);

	localparam logic [LEN_W-1:0] PLEN   = LEN_W'(PAYLOAD_BITS);
	localparam int               SH_TOP = BLOCK_W - PAYLOAD_BITS;

	logic [LEN_W-1:0]   len_c;
	logic [VALUE_W-1:0] val_m;
	logic [LEN_W-1:0]   fill_c;
	logic [LEN_W:0]     room;
	logic               fits;
	logic [LEN_W:0]     sh_fit;
	logic [BLOCK_W-1:0] place_fit;
	logic [LEN_W-1:0]   rest;
	logic [VALUE_W-1:0] upper;
	logic [BLOCK_W-1:0] place_top;
	logic [VALUE_W-1:0] rest_m;
	logic [BLOCK_W-1:0] place_rest;

	always_comb begin
		len_c  = (field_length > PLEN) ? PLEN : field_length;
		val_m  = field_value & ~({VALUE_W{1'b1}} << len_c);
		fill_c = (fill_q >= PLEN) ? '0 : fill_q;
		room   = {1'b0, PLEN} - {1'b0, fill_c};
		fits   = {1'b0, len_c} < room;

		sh_fit    = (LEN_W+1)'(BLOCK_W) - {1'b0, fill_c} - {1'b0, len_c};
		place_fit = {1'b0, val_m} << sh_fit;

		// split case: upper bits close the payload, low bits open a new block
		rest       = len_c - room[LEN_W-1:0];
		upper      = val_m >> rest;
		place_top  = {1'b0, upper} << SH_TOP;
		rest_m     = val_m & ~({VALUE_W{1'b1}} << rest);
		place_rest = {1'b0, rest_m} << ((LEN_W+1)'(BLOCK_W) - {1'b0, rest});

		res.update     = 1'b0;
		res.emit       = 1'b0;
		res.emit_block = block_q | place_top;
		res.next_block = place_rest;
		res.next_fill  = rest;

		if (cmd == CMD_END) begin
			res.update     = 1'b1;
			res.emit       = 1'b1;
			res.emit_block = block_q | BLOCK_W'(1);
			res.next_block = '0;
			res.next_fill  = '0;
		end else if (len_c != '0) begin
			res.update = 1'b1;
			if (fits) begin
				res.next_block = block_q | place_fit;
				res.next_fill  = fill_c + len_c;
			end else begin
				res.emit = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/vlbp_out_buf.sv @@
`default_nettype none

// Two-block buffer that sends each block as two words, upper half first.
module vlbp_out_buf import vlbp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [BLOCK_W-1:0] push_block,
	output logic                    full,
	vlbp_out_if.source              dout
);

	logic [BLOCK_W-1:0] blk_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               half_q;
	logic               pop;
	logic               pop_blk;

	assign full    = (cnt_q == 2'd2);
	assign pop     = dout.valid && dout.ready;
	assign pop_blk = pop && half_q;

	assign dout.valid       = (cnt_q != 2'd0);
	assign dout.out_word    = half_q ? blk_q[rd_ptr_q][WORD_W-1:0]
	                                 : blk_q[rd_ptr_q][BLOCK_W-1:WORD_W];
	assign dout.last_of_run = half_q;

	always_ff @(posedge clk) begin
		if (push) begin
			blk_q[wr_ptr_q] <= push_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			half_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				half_q <= ~half_q;
			end
			if (pop_blk) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_blk};
		end
	end

endmodule

`default_nettype wire

@@ rtl/variable_length_bit_packer_core.sv @@
// Variable-length bit packer. Each din transaction either appends the low
// field_length bits of field_value (capped at PAYLOAD_BITS) MSB-first to the
// current 64-bit block, or, with cmd = end, sets bit 0 of the block and
// flushes it. The upper PAYLOAD_BITS bits of a block carry payload; the bits
// below down to bit 1 stay zero and bit 0 is the end-of-stream flag. A field
// that overflows the block is split: its upper part closes the block and the
// rest opens the next one. Every finished block leaves on dout as two 32-bit
// transactions, upper half first, last_of_run high on the lower half.
// The item is registered, merged into the block combinationally, and a
// finished block lands in a two-block output buffer, which sends it on dout
// upper word first. din can take a new item while the previous one is being
// merged, keeps accepting while the buffer drains, and stalls only when an
// item finishes a block while both buffered blocks are still pending.
`default_nettype none

module variable_length_bit_packer_core import vlbp_pkg::*; #(
	parameter int PAYLOAD_BITS = vlbp_pkg::PAYLOAD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vlbp_in_if.sink   din,
	vlbp_out_if.source dout
);

	// input register
	logic               valid_s1;
	logic               cmd_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [LEN_W-1:0]   length_s1;

	// block under construction
	logic [BLOCK_W-1:0] block_q;
	logic [LEN_W-1:0]   fill_q;

	pack_res_t res;
	logic      buf_full;
	logic      go;       // registered item retires this cycle
	logic      accept;

	// an item that emits waits only if both buffered blocks are still pending
	assign go        = valid_s1 && (!res.emit || !buf_full);
	assign din.ready = !valid_s1 || go;
	assign accept    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= din.cmd;
			value_s1  <= din.field_value;
			length_s1 <= din.field_length;
		end
	end

	vlbp_pack #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_pack (
		.cmd         (cmd_s1),
		.field_value (value_s1),
		.field_length(length_s1),
		.block_q     (block_q),
		.fill_q      (fill_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
			fill_q  <= '0;
		end else if (go && res.update) begin
			block_q <= res.next_block;
			fill_q  <= res.next_fill;
		end
	end

	vlbp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go && res.emit),
		.push_block(res.emit_block),
		.full      (buf_full),
		.dout      (dout)
	);

endmodule

`default_nettype wire

@@ rtl/vlbp_checker.sv @@
`default_nettype none

module vlbp_checker import vlbp_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [WORD_W-1:0] out_word,
	input wire logic              out_last
);

	// lower half is always on hand right after the upper half goes
	a_lower_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_last)
		else $error("lower half not presented after upper half");

	// a fresh block always starts with its upper half
	a_upper_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid || !out_last)
		else $error("block started with lower half");

	// with nothing buffered the block cannot hold off input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output buffer");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("output transaction changed while stalled");

endmodule

bind variable_length_bit_packer_core vlbp_checker u_vlbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (din.ready),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.out_word (dout.out_word),
	.out_last (dout.last_of_run)
);

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
	import vlbp_pkg::*;

	// Generous ceiling: ~900 transactions, each worst case a full sender gap,
	// two words each behind a full receiver stall, plus pipeline cycles.
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 850;
	localparam int TAIL_CYCLES = 32;
	localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

	// One 32-bit half of a finished block, as it should leave on dout.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} block_half_t;

	// Tracks the block under construction and the words it must produce.
	class packed_word_scoreboard;
		logic [BLOCK_W-1:0] block;
		logic [LEN_W-1:0]   fill;
		block_half_t        expected_words[$];
		int                 errors;
		int                 words_seen;

		function new();
			block = '0;
			fill = '0;
			errors = 0;
			words_seen = 0;
		endfunction

		function logic [BLOCK_W-1:0] low_ones(int unsigned n);
			if (n == 0)
				return '0;
			return {BLOCK_W{1'b1}} >> (BLOCK_W - n);
		endfunction

		function void queue_block();
			block_half_t half;
			half.word = block[BLOCK_W-1:WORD_W];
			half.last = 1'b0;
			expected_words.insert(expected_words.size(), half);
			half.word = block[WORD_W-1:0];
			half.last = 1'b1;
			expected_words.insert(expected_words.size(), half);
			block = '0;
			fill = '0;
		endfunction

		// Merge one accepted din transaction into the block.
		function void note_item(logic cmd, logic [VALUE_W-1:0] value,
			logic [LEN_W-1:0] length);
			int unsigned len;
			int unsigned used;
			int unsigned room;
			int unsigned rest;
			logic [BLOCK_W-1:0] bits;
			if (cmd == CMD_END) begin
				block |= 64'd1;
				queue_block();
				return;
			end
			len = (length > PAYLOAD_BITS) ? PAYLOAD_BITS : length;
			if (len == 0)
				return;
			bits = {1'b0, value} & low_ones(len);
			used = (fill >= PAYLOAD_BITS) ? 0 : fill;
			room = PAYLOAD_BITS - used;
			if (len < room) begin
				block |= bits << (BLOCK_W - used - len);
				fill = LEN_W'(used + len);
			end else begin
				// upper part closes this block, the rest opens the next one
				rest = len - room;
				block |= (bits >> rest) << (BLOCK_W - PAYLOAD_BITS);
				queue_block();
				if (rest > 0) begin
					block = (bits & low_ones(rest)) << (BLOCK_W - rest);
					fill = LEN_W'(rest);
				end
			end
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_word(logic [WORD_W-1:0] word, logic last);
			block_half_t exp_half;
			words_seen++;
			if (expected_words.size() == 0) begin
				report($sformatf("word %0d: unexpected word %h last %b",
					words_seen, word, last));
			end else begin
				exp_half = expected_words.pop_front();
				if (word !== exp_half.word)
					report($sformatf("word %0d: out_word %h, expected %h",
						words_seen, word, exp_half.word));
				if (last !== exp_half.last)
					report($sformatf("word %0d: last_of_run %b, expected %b",
						words_seen, last, exp_half.last));
			end
		endtask

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	vlbp_in_if  din_if ();
	vlbp_out_if dout_if ();

	variable_length_bit_packer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	packed_word_scoreboard sb = new();

	int cycles = 0;
	int items_sent = 0;
	int ends_sent = 0;
	int empties_sent = 0;
	int send_quiet = 0;
	int recv_quiet = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the handshake hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d words outstanding", cycles,
				sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// Per-transaction wait drawn at random, with occasional runs of no idling
	// so back-to-back traffic also hits every phase of the block.
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			quiet = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Drive one din transaction. Entered and left on a rising edge; valid
	// stays high across back-to-back transactions (no low/high in one step).
	task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] value,
		input logic [LEN_W-1:0] length);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid        <= 1'b1;
		din_if.cmd          <= cmd;
		din_if.field_value  <= value;
		din_if.field_length <= length;
		do @(posedge clk); while (!din_if.ready);
		sb.note_item(cmd, value, length);
		items_sent++;
		if (cmd == CMD_END)
			ends_sent++;
		else if (length == 0)
			empties_sent++;
	endtask

	// Hold din idle until every predicted word has drained.
	task automatic drain_pause();
		din_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// dout sink: random stalls per word.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap(recv_quiet);
			if (stall > 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!(dout_if.valid && dout_if.ready));
		end
	end

	// dout monitor: every accepted word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready)
			sb.check_word(dout_if.out_word, dout_if.last_of_run);
	end

	initial begin
		int kind;
		logic cmd;
		logic [VALUE_W-1:0] val;
		logic [LEN_W-1:0] len;

		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.cmd = CMD_APPEND;
		din_if.field_value = '0;
		din_if.field_length = '0;
		dout_if.ready = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty fields, end on an empty block, exact fills, splits,
		// excess value bits, ignored fields on end, back-to-back ends.
		send_item(CMD_APPEND, ALL_ONES, 6'd0);
		send_item(CMD_END, '0, 6'd0);
		send_item(CMD_APPEND, ALL_ONES, 6'd63);
		send_item(CMD_APPEND, '0, 6'd63);
		send_item(CMD_APPEND, ALL_ONES, 6'd1);
		send_item(CMD_APPEND, 63'h2AAA_AAAA_AAAA_AAAA, 6'd63);
		send_item(CMD_APPEND, 63'h5555_5555_5555_5555, 6'd62);
		send_item(CMD_APPEND, 63'h1234_5678, 6'd31);
		send_item(CMD_APPEND, 63'hF_FFFF_0000, 6'd32);
		send_item(CMD_APPEND, 63'h5A, 6'd7);
		send_item(CMD_END, ALL_ONES, 6'd63);
		send_item(CMD_APPEND, ALL_ONES, 6'd62);
		send_item(CMD_APPEND, 63'h3, 6'd2);
		send_item(CMD_APPEND, '0, 6'd0);
		send_item(CMD_APPEND, ALL_ONES, 6'd61);
		send_item(CMD_APPEND, 63'h4000_0000_0000_0000, 6'd63);
		send_item(CMD_END, 63'h5555_5555_5555_5555, 6'd42);
		send_item(CMD_END, '0, 6'd0);
		send_item(CMD_APPEND, 63'h1, 6'd1);
		send_item(CMD_END, 63'h2AAA_AAAA_AAAA_AAAA, 6'd21);

		drain_pause();

		// Random: mostly appends, short fields favored so blocks build up
		// from many pieces; long fields force splits at every fill level.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain_pause();
			kind = $urandom_range(0, 15);
			val = VALUE_W'({$urandom, $urandom});
			if (kind == 0)
				val = ALL_ONES;
			else if (kind == 1)
				val = '0;
			cmd = ($urandom_range(0, 11) == 0) ? CMD_END : CMD_APPEND;
			case ($urandom_range(0, 9))
				0: len = 6'd0;
				1: len = 6'd63;
				2, 3, 4, 5: len = LEN_W'($urandom_range(1, 8));
				6, 7, 8: len = LEN_W'($urandom_range(1, 63));
				default: len = LEN_W'($urandom_range(56, 63));
			endcase
			send_item(cmd, val, len);
		end

		din_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// extra cycles to catch stray words after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d din transactions (%0d end commands, %0d empty fields)",
			items_sent, ends_sent, empties_sent);
		$display("Checked %0d dout words in %0d cycles", sb.words_seen, cycles);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
